// ===== design/magic_sync_frame_deframer_assert.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef MAGIC_SYNC_FRAME_DEFRAMER_ASSERT_SVH
`define MAGIC_SYNC_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// Check that a condition implies a consequence in the same cycle.
`define MSFD_ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("deframer assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define MSFD_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("deframer assertion failed");
`else
`define MSFD_ASSERT_IMPLIES(label, clk, rst_n, cond, cons)
`define MSFD_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif

`endif

// ===== design/msfd_pkg.sv =====
package msfd_pkg;

	// Frame layout
	localparam int unsigned HEADER_BYTES = 20;
	localparam int unsigned HDR_CNT_W    = 5;
	localparam int unsigned SYNC_LEN     = 4;

	localparam logic [HDR_CNT_W-1:0] POS_VERSION     = 5'd4;
	localparam logic [HDR_CNT_W-1:0] POS_TYPE        = 5'd5;
	localparam logic [HDR_CNT_W-1:0] POS_LEN_FIRST   = 5'd8;
	localparam logic [HDR_CNT_W-1:0] POS_LEN_LAST    = 5'd11;
	localparam logic [HDR_CNT_W-1:0] POS_STAMP_FIRST = 5'd12;
	localparam logic [HDR_CNT_W-1:0] POS_STAMP_LAST  = HDR_CNT_W'(HEADER_BYTES - 1);

	// Sync word "CCAM", first byte in element 0
	localparam logic [SYNC_LEN-1:0][7:0] SYNC_WORD = {8'h4D, 8'h41, 8'h43, 8'h43};
	localparam logic [1:0] SYNC_LAST = 2'(SYNC_LEN - 1);

	// Configuration port
	localparam int unsigned CFG_DATA_W  = 25;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXP_VERSION = 2'd1;
	localparam logic [CFG_DATA_W-1:0]  MAX_PAYLOAD_RESET = 25'h100_0000;
	localparam logic [7:0]             EXP_VERSION_RESET = 8'd1;

	typedef enum logic [1:0] {
		KIND_HDR_OK  = 2'd0,
		KIND_HDR_REJ = 2'd1,
		KIND_PAYLOAD = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  msg_type;
		logic [31:0] payload_length;
		logic [63:0] header_time_us;
		logic [7:0]  payload_byte;
		logic [23:0] payload_index;
		logic        last;
	} result_t;

endpackage

// ===== design/magic_sync_frame_deframer.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// input    | in_valid / in_ready   | data_byte
// output   | out_valid / out_ready | kind, msg_type, payload_length,
//          |                       | header_time_us, payload_byte, payload_index,
//          |                       | last
// config   | cfg_we                | cfg_index, cfg_data
//
// One byte is accepted per cycle while in_ready is high; its result, if any,
// is registered in main, or in skid while main holds a result not yet taken.
// A two-entry output buffer (main register plus skid) lets input flow while
// one result waits; in_ready drops only while both entries are full.
// Reset returns to sync hunting with the limit at 16777216 and version 1.
module magic_sync_frame_deframer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          kind,
	output logic [7:0]                          msg_type,
	output logic [31:0]                         payload_length,
	output logic [63:0]                         header_time_us,
	output logic [7:0]                          payload_byte,
	output logic [23:0]                         payload_index,
	output logic                                last,
	input  logic                                cfg_we,
	input  logic [msfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [msfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	// Configuration registers
	logic [24:0] max_payload_q;
	logic [7:0]  exp_version_q;

	// Frame state
	phase_t                          phase_q, phase_d;
	logic [1:0]                      sync_q, sync_d;
	logic [msfd_pkg::HDR_CNT_W-1:0]  cnt_q, cnt_d;
	logic [7:0]                      ver_q, ver_d;
	logic [7:0]                      type_q, type_d;
	logic [31:0]                     len_q, len_d;
	logic [63:0]                     stamp_q, stamp_d;
	logic [24:0]                     left_q, left_d;

	// Output buffer
	logic                main_v_q, skid_v_q;
	msfd_pkg::result_t   main_q, skid_q;
	msfd_pkg::result_t   res;
	logic                res_v;

	logic accept_in;

	assign in_ready  = !skid_v_q;
	assign accept_in = in_valid && in_ready;

	// Write configuration; drop indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= msfd_pkg::MAX_PAYLOAD_RESET;
			exp_version_q <= msfd_pkg::EXP_VERSION_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				msfd_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				msfd_pkg::CFG_EXP_VERSION: exp_version_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Compute next frame state and the result of the current word
	always_comb begin
		phase_d = phase_q;
		sync_d  = sync_q;
		cnt_d   = cnt_q;
		ver_d   = ver_q;
		type_d  = type_q;
		len_d   = len_q;
		stamp_d = stamp_q;
		left_d  = left_q;
		res_v   = 1'b0;
		res     = '0;
		unique case (phase_q)
			PH_HEADER: begin
				if (cnt_q == msfd_pkg::POS_VERSION) begin
					ver_d = data_byte;
				end else if (cnt_q == msfd_pkg::POS_TYPE) begin
					type_d = data_byte;
				end else if (cnt_q >= msfd_pkg::POS_LEN_FIRST &&
					cnt_q <= msfd_pkg::POS_LEN_LAST) begin
					len_d = {len_q[23:0], data_byte};
				end else if (cnt_q >= msfd_pkg::POS_STAMP_FIRST) begin
					stamp_d = {stamp_q[55:0], data_byte};
				end
				cnt_d = cnt_q + 1'b1;
				// Judge the header on its last word
				if (cnt_q == msfd_pkg::POS_STAMP_LAST) begin
					cnt_d              = '0;
					sync_d             = '0;
					res_v              = 1'b1;
					res.msg_type       = type_d;
					res.payload_length = len_d;
					res.header_time_us = stamp_d;
					if (ver_d != exp_version_q || len_d > {7'd0, max_payload_q}) begin
						phase_d  = PH_HUNT;
						res.kind = msfd_pkg::KIND_HDR_REJ;
					end else begin
						res.kind = msfd_pkg::KIND_HDR_OK;
						if (len_d == 32'd0) begin
							phase_d = PH_HUNT;
						end else begin
							phase_d = PH_PAYLOAD;
							left_d  = len_d[24:0];
						end
					end
				end
			end
			PH_PAYLOAD: begin
				res_v              = 1'b1;
				res.kind           = msfd_pkg::KIND_PAYLOAD;
				res.msg_type       = type_q;
				res.payload_length = len_q;
				res.header_time_us = stamp_q;
				res.payload_byte   = data_byte;
				res.payload_index  = len_q[23:0] - left_q[23:0];
				res.last           = (left_q <= 25'd1);
				left_d             = left_q - 1'b1;
				if (res.last) begin
					left_d  = '0;
					phase_d = PH_HUNT;
				end
			end
			default: begin
				// Hunt for the sync word; a stray 'C' restarts at one byte
				phase_d = PH_HUNT;
				if (data_byte == msfd_pkg::SYNC_WORD[sync_q]) begin
					if (sync_q == msfd_pkg::SYNC_LAST) begin
						sync_d  = '0;
						phase_d = PH_HEADER;
						cnt_d   = msfd_pkg::POS_VERSION;
						ver_d   = '0;
						type_d  = '0;
						len_d   = '0;
						stamp_d = '0;
					end else begin
						sync_d = sync_q + 1'b1;
					end
				end else if (data_byte == msfd_pkg::SYNC_WORD[0]) begin
					sync_d = 2'd1;
				end else begin
					sync_d = '0;
				end
			end
		endcase
	end

	// Hold frame state and the output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			sync_q   <= '0;
			cnt_q    <= '0;
			ver_q    <= '0;
			type_q   <= '0;
			len_q    <= '0;
			stamp_q  <= '0;
			left_q   <= '0;
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
			main_q   <= '0;
			skid_q   <= '0;
		end else begin
			// Advance the frame on each accepted word
			if (accept_in) begin
				phase_q <= phase_d;
				sync_q  <= sync_d;
				cnt_q   <= cnt_d;
				ver_q   <= ver_d;
				type_q  <= type_d;
				len_q   <= len_d;
				stamp_q <= stamp_d;
				left_q  <= left_d;
			end
			// Refill main from skid, else load new results into main or skid
			if (skid_v_q) begin
				if (out_ready) begin
					main_q   <= skid_q;
					skid_v_q <= 1'b0;
				end
			end else if (!main_v_q || out_ready) begin
				main_v_q <= accept_in && res_v;
				main_q   <= res;
			end else if (accept_in && res_v) begin
				skid_v_q <= 1'b1;
				skid_q   <= res;
			end
		end
	end

	assign out_valid      = main_v_q;
	assign kind           = main_q.kind;
	assign msg_type       = main_q.msg_type;
	assign payload_length = main_q.payload_length;
	assign header_time_us = main_q.header_time_us;
	assign payload_byte   = main_q.payload_byte;
	assign payload_index  = main_q.payload_index;
	assign last           = main_q.last;

`include "magic_sync_frame_deframer_assert.svh"

	`MSFD_ASSERT_IMPLIES(a_skid_needs_main, clk, arst_n, skid_v_q, main_v_q)
	`MSFD_ASSERT_IMPLIES(a_payload_left, clk, arst_n, phase_q == PH_PAYLOAD, left_q != 25'd0)
	`MSFD_ASSERT_IMPLIES(a_header_count, clk, arst_n, phase_q == PH_HEADER, cnt_q >= msfd_pkg::POS_VERSION && cnt_q <= msfd_pkg::POS_STAMP_LAST)
	`MSFD_ASSERT_NEXT(a_last_to_hunt, clk, arst_n, accept_in && phase_q == PH_PAYLOAD && left_q == 25'd1, phase_q == PH_HUNT)

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import msfd_pkg::*;

	localparam int IDLE_PCT       = 13;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;

	// Indexes the block decodes as no register
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum logic [1:0] {
		ST_HUNT    = 2'd0,
		ST_HEADER  = 2'd1,
		ST_PAYLOAD = 2'd2
	} deframe_state_t;

	logic                   clk            = 1'b0;
	logic                   arst_n         = 1'b0;
	logic                   in_valid       = 1'b0;
	logic                   in_ready;
	logic [7:0]             data_byte      = 8'd0;
	logic                   out_valid;
	logic                   out_ready      = 1'b0;
	logic [1:0]             kind;
	logic [7:0]             msg_type;
	logic [31:0]            payload_length;
	logic [63:0]            header_time_us;
	logic [7:0]             payload_byte;
	logic [23:0]            payload_index;
	logic                   last;
	logic                   cfg_we         = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index      = '0;
	logic [CFG_DATA_W-1:0]  cfg_data       = '0;

	// Deframer state as predicted, at reset values
	logic [24:0]    max_len    = MAX_PAYLOAD_RESET;
	logic [7:0]     want_ver   = EXP_VERSION_RESET;
	deframe_state_t st         = ST_HUNT;
	logic [2:0]     sync_cnt   = '0;
	logic [4:0]     hdr_pos    = '0;
	logic [7:0]     ver_seen   = '0;
	logic [7:0]     typ_seen   = '0;
	logic [31:0]    len_seen   = '0;
	logic [63:0]    stamp_seen = '0;
	logic [24:0]    bytes_left = '0;

	logic [7:0] stream_bytes[$];
	result_t    pending_results[$];

	logic in_taken  = 1'b0;
	logic steady    = 1'b0;
	logic hold_req  = 1'b0;
	int   hold_left = 0;
	int   quiet     = 0;
	int   errors    = 0;
	int   pushed    = 0;
	int   hdr_ok    = 0;
	int   hdr_rej   = 0;
	int   body_seen = 0;
	int   settings  = 1;

	magic_sync_frame_deframer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.msg_type       (msg_type),
		.payload_length (payload_length),
		.header_time_us (header_time_us),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t make_result(kind_t k, logic [7:0] pb, logic [23:0] pi,
			logic fin);
		result_t r;
		r.kind           = k;
		r.msg_type       = typ_seen;
		r.payload_length = len_seen;
		r.header_time_us = stamp_seen;
		r.payload_byte   = pb;
		r.payload_index  = pi;
		r.last           = fin;
		return r;
	endfunction

	// Advance the predicted deframer by one byte and queue its result, if any
	task automatic deframe_byte(input logic [7:0] b);
		logic [4:0]  pos;
		logic [23:0] idx;
		logic        fin;
		case (st)
			ST_HEADER: begin
				pos = hdr_pos;
				if (pos == POS_VERSION)
					ver_seen = b;
				else if (pos == POS_TYPE)
					typ_seen = b;
				else if (pos >= POS_LEN_FIRST && pos <= POS_LEN_LAST)
					len_seen = {len_seen[23:0], b};
				else if (pos >= POS_STAMP_FIRST && pos <= POS_STAMP_LAST)
					stamp_seen = {stamp_seen[55:0], b};
				hdr_pos = pos + 5'd1;
				if (hdr_pos >= HEADER_BYTES) begin
					hdr_pos  = '0;
					sync_cnt = '0;
					if (ver_seen != want_ver || len_seen > {7'd0, max_len}) begin
						st = ST_HUNT;
						pending_results.push_back(make_result(KIND_HDR_REJ, 8'd0, 24'd0, 1'b0));
					end else begin
						if (len_seen == 32'd0) begin
							st = ST_HUNT;
						end else begin
							st         = ST_PAYLOAD;
							bytes_left = len_seen[24:0];
						end
						pending_results.push_back(make_result(KIND_HDR_OK, 8'd0, 24'd0, 1'b0));
					end
				end
			end
			ST_PAYLOAD: begin
				idx        = len_seen[23:0] - bytes_left[23:0];
				fin        = (bytes_left <= 25'd1);
				bytes_left = bytes_left - 25'd1;
				if (fin) begin
					bytes_left = '0;
					st         = ST_HUNT;
				end
				pending_results.push_back(make_result(KIND_PAYLOAD, b, idx, fin));
			end
			default: begin
				// hunt for the sync word; a stray 'C' restarts the match at one
				st = ST_HUNT;
				if (sync_cnt < 3'(SYNC_LEN) && b == SYNC_WORD[sync_cnt[1:0]])
					sync_cnt = sync_cnt + 3'd1;
				else if (b == SYNC_WORD[0])
					sync_cnt = 3'd1;
				else
					sync_cnt = 3'd0;
				if (sync_cnt >= 3'(SYNC_LEN)) begin
					sync_cnt   = '0;
					st         = ST_HEADER;
					hdr_pos    = HDR_CNT_W'(SYNC_LEN);
					ver_seen   = '0;
					typ_seen   = '0;
					len_seen   = '0;
					stamp_seen = '0;
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Present byte words; hold each until taken, with random gaps
	always @(negedge clk) begin : drv
		logic       v_next;
		logic [7:0] b_next;
		v_next = in_valid;
		b_next = data_byte;
		if (in_taken)
			v_next = 1'b0;
		in_taken = 1'b0;
		if (!v_next && arst_n && stream_bytes.size() != 0 &&
				(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
			b_next = stream_bytes.pop_front();
			v_next = 1'b1;
		end
		in_valid  <= v_next;
		data_byte <= b_next;
	end

	// Drive out_ready: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Check each result word against the oldest prediction, then predict new input words
	always @(posedge clk) begin : mon
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result word, kind %0d, expected none", $time, kind);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("kind", want.kind, kind);
					check_field("msg_type", want.msg_type, msg_type);
					check_field("payload_length", want.payload_length, payload_length);
					check_field("header_time_us", want.header_time_us, header_time_us);
					check_field("payload_byte", want.payload_byte, payload_byte);
					check_field("payload_index", want.payload_index, payload_index);
					check_field("last", want.last, last);
					case (want.kind)
						KIND_HDR_OK:  hdr_ok++;
						KIND_HDR_REJ: hdr_rej++;
						default:      body_seen++;
					endcase
				end
			end
			if (in_valid && in_ready) begin
				deframe_byte(data_byte);
				in_taken = 1'b1;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[magic_sync_frame_deframer] ERROR");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		stream_bytes.push_back(b);
		pushed++;
	endtask

	task automatic push_header(input logic [7:0] ver, input logic [7:0] typ,
			input logic [31:0] len, input logic [63:0] stamp);
		for (int i = 0; i < SYNC_LEN; i++)
			push_byte(SYNC_WORD[i]);
		push_byte(ver);
		push_byte(typ);
		push_byte(8'($urandom_range(0, 255)));
		push_byte(8'($urandom_range(0, 255)));
		for (int i = 3; i >= 0; i--)
			push_byte(len[8*i +: 8]);
		for (int i = 7; i >= 0; i--)
			push_byte(stamp[8*i +: 8]);
	endtask

	task automatic push_body(input int n);
		repeat (n)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	// Mostly good frames with random content; the rest bad headers and sync noise
	task automatic random_frame();
		int          r;
		int          k;
		logic [31:0] len;
		logic [7:0]  junk;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			k = $urandom_range(0, 99);
			if (k < 10)
				len = 32'd0;
			else if (k < 75)
				len = $urandom_range(1, 8);
			else if (k < 95)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 120);
			if (len > {7'd0, max_len})
				len = {7'd0, max_len};
			push_header(want_ver, 8'($urandom_range(0, 255)), len, {$urandom, $urandom});
			push_body(len);
		end else if (r < 80) begin
			push_header(want_ver ^ 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
				$urandom, {$urandom, $urandom});
		end else if (r < 90) begin
			if ($urandom_range(0, 1) == 0)
				len = {7'd0, max_len} + 32'd1 + 32'($urandom_range(0, 1000));
			else
				len = $urandom | 32'h8000_0000;
			push_header(want_ver, 8'($urandom_range(0, 255)), len, {$urandom, $urandom});
		end else begin
			// broken sync: a partial match, then a byte that does not extend it
			k = $urandom_range(1, SYNC_LEN - 1);
			for (int i = 0; i < k; i++)
				push_byte(SYNC_WORD[i]);
			junk = 8'($urandom_range(0, 255));
			if (junk == SYNC_WORD[k])
				junk = junk ^ 8'h01;
			push_byte(junk);
		end
	endtask

	task automatic random_stream(input int n);
		int start;
		start = pushed;
		while (pushed - start < n)
			random_frame();
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == CFG_MAX_PAYLOAD)
			max_len = value;
		else if (idx == CFG_EXP_VERSION)
			want_ver = value[7:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every byte is taken and every result has come, then let the pipe drain
	task automatic wait_idle();
		while (stream_bytes.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: sync restart, both payload extremes, zero length, rejects
		push_byte(SYNC_WORD[0]);
		push_byte(SYNC_WORD[1]);
		push_header(EXP_VERSION_RESET, 8'hFF, 32'd2, '1);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(SYNC_WORD[0]);
		push_byte(SYNC_WORD[1]);
		push_byte(SYNC_WORD[2]);
		push_byte(8'h00);
		push_header(EXP_VERSION_RESET, 8'h00, 32'd0, '0);
		push_header(8'h02, 8'h5A, 32'd3, {$urandom, $urandom});
		push_header(EXP_VERSION_RESET, 8'h11, 32'h0100_0001, {$urandom, $urandom});
		push_header(EXP_VERSION_RESET, 8'h22, 32'hFFFF_FFFF, {$urandom, $urandom});
		random_stream(280);
		wait_idle();

		// Low extremes: only empty payloads with version zero pass
		cfg_write(CFG_MAX_PAYLOAD, '0);
		cfg_write(CFG_EXP_VERSION, '0);
		settings++;
		push_header(8'h00, 8'h00, 32'd1, '0);
		random_stream(280);
		wait_idle();

		// High extremes, with no idling on either side
		cfg_write(CFG_MAX_PAYLOAD, '1);
		cfg_write(CFG_EXP_VERSION, CFG_DATA_W'(8'hFF));
		settings++;
		steady = 1'b1;
		push_header(8'hFF, 8'h80, 32'h0200_0000, {$urandom, $urandom});
		random_stream(300);
		wait_idle();
		steady = 1'b0;

		// Spare indexes must change nothing; then a payload at the limit under back-pressure
		cfg_write(CFG_SPARE_A, CFG_DATA_W'($urandom));
		cfg_write(CFG_SPARE_B, CFG_DATA_W'($urandom));
		cfg_write(CFG_MAX_PAYLOAD, CFG_DATA_W'(300));
		cfg_write(CFG_EXP_VERSION, CFG_DATA_W'(8'hA5));
		settings++;
		push_header(8'hA5, 8'h3C, 32'd300, {$urandom, $urandom});
		push_body(300);
		hold_req = 1'b1;
		random_stream(200);
		wait_idle();

		// Random small limit and random version
		cfg_write(CFG_MAX_PAYLOAD, CFG_DATA_W'($urandom_range(1, 64)));
		cfg_write(CFG_EXP_VERSION, CFG_DATA_W'($urandom_range(0, 255)));
		settings++;
		random_stream(300);
		wait_idle();

		$display("Sent %0d bytes under %0d register settings, including a long output stall.",
			pushed, settings);
		$display("Checked %0d accepted headers, %0d rejected headers and %0d payload bytes.",
			hdr_ok, hdr_rej, body_seen);
		if (errors == 0)
			$display("[magic_sync_frame_deframer] OK");
		else
			$display("[magic_sync_frame_deframer] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/msfd_pkg.sv
design/magic_sync_frame_deframer.sv
sim/tb_top.sv
